FILE: rtl/sge_pkg.sv
// Shared types and constants for the Sobel edge gradient block.
// No dependencies.
package sge_pkg;

   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 4096;
   localparam int AddrW     = $clog2(MaxWidth);
   localparam int RootW     = 11;
   localparam int RadW      = 2 * RootW;

   localparam logic [11:0] WidthReset  = 12'd640;
   localparam logic [12:0] HeightReset = 13'd480;
   localparam logic [15:0] EsScale     = 16'd65025;

   typedef enum logic [0:0] {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic             start;
      logic [RadW-1:0]  radicand;
   } sq_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [RootW-1:0] root;
   } sq_rsp_type;

endpackage

FILE: rtl/sge_line_store.sv
// Two line stores holding the previous two rows of the frame.
// Depends on sge_pkg.
module sge_line_store (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [sge_pkg::AddrW-1:0] rd_addr,
   output logic [7:0]               rd_top,
   output logic [7:0]               rd_mid,
   input  logic                     wr_en,
   input  logic [sge_pkg::AddrW-1:0] wr_addr,
   input  logic [7:0]               wr_top,
   input  logic [7:0]               wr_mid
);
   import sge_pkg::*;

   logic [7:0] store_a [MaxWidth];   // row above current
   logic [7:0] store_b [MaxWidth];   // two rows above
   logic [7:0] top_ff;
   logic [7:0] mid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_b[wr_addr] <= wr_top;
         store_a[wr_addr] <= wr_mid;
      end
      if (rd_en) begin
         top_ff <= store_b[rd_addr];
         mid_ff <= store_a[rd_addr];
      end
   end

   assign rd_top = top_ff;
   assign rd_mid = mid_ff;
endmodule

FILE: rtl/sge_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on sge_pkg.
module sge_isqrt (
   input  logic                clock,
   input  logic                reset,
   input  sge_pkg::sq_req_type req,
   output sge_pkg::sq_rsp_type rsp
);
   import sge_pkg::*;

   logic [RadW-1:0]  val_ff, val_in;
   logic [RootW+2:0] rem_ff, rem_in;
   logic [RootW-1:0] root_ff, root_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RootW+2:0] rem_t;
   logic [RootW+2:0] trial;

   always_comb begin
      rem_t   = {rem_ff[RootW:0], val_ff[RadW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         val_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 4'(RootW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[RadW-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {root_ff[RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {root_ff[RootW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.root = root_ff;
endmodule

FILE: rtl/sobel_edge_gradient.sv
// Sobel 3x3 edge detector top level: window, gradients, direction, output.
// Depends on sge_pkg, sge_line_store, sge_isqrt.
//
//  channel | ports            | payload
//  --------+------------------+--------------------------------------------
//  input   | req_t*           | tdata[7:0] pixel
//  result  | rsp_t*           | tdata gx,gy,mag,strength,dir; tlast frame end
//  config  | csr_we/addr/wdata| 0 image_width, 1 image_height
//
// Flow: a border pixel is accepted and then read against the line stores;
// an interior pixel also runs the shared bit-serial square root twice
// (magnitude, then edge strength), each run being a launch, the 11 root
// bits and done.
// Reset: synchronous, clears counters, window and control; line stores
// stay undefined and need no clearing pass.
// Stalls: one finished result waits in the output register while the next
// pixel is accepted; only the final load waits on a busy output.
module sobel_edge_gradient (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // grad_x, grad_y, gradient_magnitude,
                                    // edge_strength, direction_bin, zero fill
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [12:0] csr_wdata
);
   import sge_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_READ    = 8'b00000010,
      S_PREP    = 8'b00000100,
      S_MAG_GO  = 8'b00001000,
      S_MAG_WT  = 8'b00010000,
      S_ES_GO   = 8'b00100000,
      S_ES_WT   = 8'b01000000,
      S_FIN     = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic [11:0] eff_w;
   logic [12:0] eff_h;

   logic [AddrW-1:0] col_ff, col_in;
   logic [11:0]      row_ff, row_in;
   logic [7:0]       win_ff [6];
   logic [7:0]       pix_ff;
   logic             last_ff;

   logic signed [10:0] gx_ff, gy_ff;
   logic [20:0]        s_ff;
   logic [21:0]        sq_sum_ff, sq_diff_ff, a2_ff;
   logic               gy_zero_ff, neg_x_ff, ay_le_ax_ff, ax_nz_ff;
   logic [RootW-1:0]   mag_ff;

   logic               out_v_ff;
   logic [47:0]        out_d_ff;
   logic               out_l_ff;

   logic [7:0] top, mid;
   logic       accept;
   logic       interior;
   sq_req_type sq_req;
   sq_rsp_type sq_rsp;

   always_comb begin
      if (width_ff < 12'd3) eff_w = 12'd3;
      else if (width_ff > 12'(MaxWidth)) eff_w = 12'(MaxWidth);
      else eff_w = width_ff;
      if (height_ff < 13'd3) eff_h = 13'd3;
      else if (height_ff > 13'(MaxHeight)) eff_h = 13'(MaxHeight);
      else eff_h = height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_WIDTH:  width_ff  <= csr_wdata[11:0];
            REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign interior   = (row_ff >= 12'd2) && (col_ff >= AddrW'(2));

   sge_line_store u_lines (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_top  (top),
      .rd_mid  (mid),
      .wr_en   (state_ff == S_READ),
      .wr_addr (col_ff),
      .wr_top  (mid),
      .wr_mid  (pix_ff)
   );

   // column and row advance, wrapping at the clamped frame size
   always_comb begin
      logic [AddrW:0] c1;
      logic [12:0]    r1;
      c1 = {1'b0, col_ff} + 1'b1;
      r1 = {1'b0, row_ff} + 1'b1;
      col_in = col_ff;
      row_in = row_ff;
      if (c1 >= eff_w) begin
         col_in = '0;
         row_in = (r1 >= eff_h) ? 12'd0 : r1[11:0];
      end else begin
         col_in = c1[AddrW-1:0];
      end
   end

   // gradients from the window plus the fresh column
   logic signed [10:0] gx_c, gy_c;
   always_comb begin
      logic [9:0] rsum, lsum, bsum, tsum;
      rsum = {2'b0, top} + {1'b0, mid, 1'b0} + {2'b0, pix_ff};
      lsum = {2'b0, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b0, win_ff[2]};
      bsum = {2'b0, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b0, pix_ff};
      tsum = {2'b0, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b0, top};
      gx_c = $signed({1'b0, rsum}) - $signed({1'b0, lsum});
      gy_c = $signed({1'b0, bsum}) - $signed({1'b0, tsum});
   end

   // magnitudes, sum and difference for the direction squares
   logic [9:0]  ax, ay;
   logic [10:0] lsum_d;
   logic [9:0]  ldiff_d;
   always_comb begin
      ax      = gx_ff[10] ? 10'(-gx_ff) : gx_ff[9:0];
      ay      = gy_ff[10] ? 10'(-gy_ff) : gy_ff[9:0];
      lsum_d  = {1'b0, ay} + {1'b0, ax};
      ldiff_d = ay - ax;
   end

   logic [7:0] es_c;
   logic [1:0] dir_c;
   always_comb begin
      logic lt22, lt67;
      es_c  = (sq_rsp.root > 11'd255) ? 8'd255 : sq_rsp.root[7:0];
      lt22  = sq_sum_ff < a2_ff;
      lt67  = ay_le_ax_ff ? ax_nz_ff : (sq_diff_ff < a2_ff);
      if (gy_zero_ff || lt22) dir_c = 2'd0;
      else if (lt67) dir_c = neg_x_ff ? 2'd3 : 2'd1;
      else dir_c = 2'd2;
   end

   logic [36:0] scaled;
   assign scaled = {16'b0, s_ff} * {21'b0, EsScale};

   always_comb begin
      sq_req.start    = (state_ff == S_MAG_GO) || (state_ff == S_ES_GO);
      sq_req.radicand = (state_ff == S_ES_GO) ? {6'b0, scaled[36:21]} : {1'b0, s_ff};
   end

   sge_isqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .rsp   (sq_rsp)
   );

   logic out_free;
   assign out_free = !out_v_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_READ;
         S_READ:   state_in = interior ? S_PREP : S_IDLE;
         S_PREP:   state_in = S_MAG_GO;
         S_MAG_GO: state_in = S_MAG_WT;
         S_MAG_WT: if (sq_rsp.done) state_in = S_ES_GO;
         S_ES_GO:  state_in = S_ES_WT;
         S_ES_WT:  if (sq_rsp.done) state_in = S_FIN;
         S_FIN:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_READ) begin
            col_ff    <= col_in;
            row_ff    <= row_in;
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= pix_ff;
         end
         if (state_ff == S_FIN && out_free) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
      if (accept) pix_ff <= req_tdata;
      if (state_ff == S_READ) begin
         gx_ff   <= gx_c;
         gy_ff   <= gy_c;
         last_ff <= ({1'b0, row_ff} == eff_h - 13'd1)
                 && ({{(12-AddrW){1'b0}}, col_ff} == eff_w - 12'd1);
      end
      if (state_ff == S_PREP) begin
         s_ff        <= 21'({11'b0, ax} * {11'b0, ax}) + 21'({11'b0, ay} * {11'b0, ay});
         sq_sum_ff   <= {11'b0, lsum_d} * {11'b0, lsum_d};
         sq_diff_ff  <= {12'b0, ldiff_d} * {12'b0, ldiff_d};
         a2_ff       <= {21'({11'b0, ax} * {11'b0, ax}), 1'b0};
         gy_zero_ff  <= (gy_ff == 11'sd0);
         neg_x_ff    <= gy_ff[10] ? (gx_ff > 11'sd0) : gx_ff[10];
         ay_le_ax_ff <= (ay <= ax);
         ax_nz_ff    <= (ax != 10'd0);
      end
      if (state_ff == S_MAG_WT && sq_rsp.done) mag_ff <= sq_rsp.root;
      if (state_ff == S_FIN && out_free) begin
         out_d_ff <= {5'b0, dir_c, es_c, mag_ff, gy_ff, gx_ff};
         out_l_ff <= last_ff;
      end
   end

   // edge strength is taken at S_FIN from the still-held root
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tlast  = out_l_ff;

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_READ)
      else $error("accepted pixel not followed by line store read");

   a_idle_sqrt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !sq_rsp.busy)
      else $error("square root busy while idle");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      sq_rsp.done |-> (state_ff == S_MAG_WT || state_ff == S_ES_WT))
      else $error("square root result outside a wait state");
endmodule

FILE: tb/sv/tb_top.sv
// Testbench for sobel_edge_gradient: frames of grey pixels in, Sobel results checked.
// A built-in predictor of the window, gradients, magnitude, strength and direction
// sets the expected results. Depends on sge_pkg and the RTL top.
module tb_top;
   import sge_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] pixel
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [10:0] grad_x, [21:11] grad_y, [32:22] magnitude,
                              // [40:33] edge_strength, [42:41] direction_bin
   logic        rsp_tlast;    // frame_last
   logic        csr_we;
   logic [0:0]  csr_addr;
   logic [12:0] csr_wdata;

   sobel_edge_gradient dut (.*);

   // one expected Sobel result
   typedef struct {
      logic [10:0] gx;
      logic [10:0] gy;
      logic [10:0] mag;
      logic [7:0]  strength;
      logic [1:0]  dir;
      logic        last;
   } sobel_result_type;

   sobel_result_type expected_results[$];

   // predictor state
   logic [7:0]  row_above[MaxWidth];   // newest stored row
   logic [7:0]  row_two_up[MaxWidth];  // the row before it
   logic [7:0]  win[6];
   int          col_pos;
   int          row_pos;
   logic [11:0] width_reg;
   logic [12:0] height_reg;

   int error_count;
   int sender_idle_pct;
   int sink_stall_pct;
   int pixels_sent;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on the whole run
   initial begin
      #(40_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp_val);
      error_count++;
   endtask

   // floor square root, up to 24-bit radicands
   function automatic int floor_root(input longint v);
      int r;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
         if (longint'(r | (1 << b)) * longint'(r | (1 << b)) <= v) r = r | (1 << b);
      end
      return r;
   endfunction

   // quantized gradient direction; tan(22.5) = sqrt2 - 1, tan(67.5) = sqrt2 + 1
   function automatic logic [1:0] quantize_direction(input int gx, input int gy);
      longint ax, ay, twice_sq;
      logic below_22, below_67, flip;
      if (gy == 0) return 2'd0;
      if (gy < 0) begin
         gx = -gx;
         gy = -gy;
      end
      flip = gx < 0;
      ax = flip ? -gx : gx;
      ay = gy;
      twice_sq = 2 * ax * ax;
      below_22 = (ay + ax) * (ay + ax) < twice_sq;
      if (ay <= ax) below_67 = ax > 0;
      else below_67 = (ay - ax) * (ay - ax) < twice_sq;
      if (below_22) return 2'd0;
      if (below_67) return flip ? 2'd3 : 2'd1;
      return 2'd2;
   endfunction

   function automatic int eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
   endfunction

   function automatic int eff_height();
      if (height_reg < 3) return 3;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
   endfunction

   // advance the predictor by one accepted pixel
   task automatic predict_pixel(input logic [7:0] p);
      int w, h, idx, gx, gy, s;
      logic [7:0] top, mid;
      sobel_result_type res;
      w = eff_width();
      h = eff_height();
      idx = col_pos % MaxWidth;
      top = row_two_up[idx];
      mid = row_above[idx];
      row_two_up[idx] = mid;
      row_above[idx] = p;
      if (row_pos >= 2 && col_pos >= 2) begin
         // columns: win[0..2] = two back (top, mid, bot), win[3..5] = one back
         gx = (top + 2 * mid + p) - (win[0] + 2 * win[1] + win[2]);
         gy = (win[2] + 2 * win[5] + p) - (win[0] + 2 * win[3] + top);
         s = gx * gx + gy * gy;
         res.gx = gx[10:0];
         res.gy = gy[10:0];
         res.mag = floor_root(s);
         res.strength = 8'(floor_root((longint'(s) * EsScale) >> 21) > 255 ? 255 :
                           floor_root((longint'(s) * EsScale) >> 21));
         res.dir = quantize_direction(gx, gy);
         res.last = (row_pos == h - 1) && (col_pos == w - 1);
         expected_results.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = p;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      col_pos = col_pos & 11'h7FF;
      row_pos = row_pos & 12'hFFF;
   endtask

   // one pixel transaction; tvalid stays high for back-to-back transactions
   task automatic send_pixel(input logic [7:0] p);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      predict_pixel(p);
      pixels_sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // all results in, then room for a border pixel still in flight
   task automatic wait_idle();
      stop_sending();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [12:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_WIDTH) width_reg = val[11:0];
      else height_reg = val;
      @(posedge clock);
   endtask

   task automatic set_frame_size(input int w, input int h);
      wait_idle();
      write_reg(REG_WIDTH, 13'(w));
      write_reg(REG_HEIGHT, 13'(h));
   endtask

   // pixel value by pattern: 0 uniform, 1 black/white, 2 ramp, 3 near-flat
   function automatic logic [7:0] pattern_pixel(input int kind, input int r, input int c);
      case (kind)
         0: return 8'($urandom_range(255));
         1: return $urandom_range(1) ? 8'd255 : 8'd0;
         2: return 8'((r * 37 + c * 23 + $urandom_range(3)) & 8'hFF);
         default: return 8'(128 + $urandom_range(6) - 3);
      endcase
   endfunction

   task automatic send_frame(input int kind);
      int w, h;
      w = eff_width();
      h = eff_height();
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) send_pixel(pattern_pixel(kind, r, c));
   endtask

   // pad the current frame out so the counters sit at the frame start
   task automatic finish_frame();
      while (col_pos != 0 || row_pos != 0) send_pixel(8'($urandom_range(255)));
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
         1: begin sender_idle_pct = 47; sink_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  sink_stall_pct = 47; end
         default: begin sender_idle_pct = 6; sink_stall_pct = 6; end
      endcase
   endtask

   // result side: random backpressure plus field-by-field compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result transaction", 1, 0);
            end else begin
               sobel_result_type e;
               e = expected_results.pop_front();
               if (rsp_tdata[10:0] !== e.gx)
                  report_mismatch("grad_x", $signed(rsp_tdata[10:0]), $signed(e.gx));
               if (rsp_tdata[21:11] !== e.gy)
                  report_mismatch("grad_y", $signed(rsp_tdata[21:11]), $signed(e.gy));
               if (rsp_tdata[32:22] !== e.mag)
                  report_mismatch("magnitude", rsp_tdata[32:22], e.mag);
               if (rsp_tdata[40:33] !== e.strength)
                  report_mismatch("edge_strength", rsp_tdata[40:33], e.strength);
               if (rsp_tdata[42:41] !== e.dir)
                  report_mismatch("direction_bin", rsp_tdata[42:41], e.dir);
               if (rsp_tdata[47:43] !== 5'd0)
                  report_mismatch("zero fill", rsp_tdata[47:43], 0);
               if (rsp_tlast !== e.last)
                  report_mismatch("frame_last", rsp_tlast, e.last);
            end
         end
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // --- tests ---

   // 3x3 frames: flat, strongest horizontal and vertical edges, a diagonal
   task automatic test_directed_edges();
      set_idle_mode(0);
      set_frame_size(3, 3);
      for (int i = 0; i < 9; i++) send_pixel(8'd0);                      // flat
      for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'd255 : 8'd0); // gx max
      for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'd255 : 8'd0);   // gy min
      for (int i = 0; i < 9; i++)
         send_pixel(((i / 3 + i % 3) > 2) ? 8'd255 : 8'd0);             // diagonal
      for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'd255 : 8'd0); // gx min
   endtask

   // out-of-range register values clamp; wide and tall frames cut short
   task automatic test_size_extremes();
      set_idle_mode(3);
      set_frame_size(0, 2);          // both clamp up to 3
      send_frame(0);
      set_frame_size(4095, 3);       // clamps to the maximum width
      for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(255)));
      set_frame_size(3, 3);
      finish_frame();
      set_idle_mode(0);
      set_frame_size(3, 8191);       // clamps to the maximum height
      for (int i = 0; i < 36; i++) send_pixel(pattern_pixel(1, i / 3, i % 3));
      set_frame_size(3, 3);
      finish_frame();
   endtask

   // shrink the frame while in the middle of one; counters then wrap at the new size
   task automatic test_resize_mid_frame();
      set_idle_mode(3);
      set_frame_size(12, 10);
      for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(255)));
      set_frame_size(6, 5);
      for (int i = 0; i < 30; i++) send_pixel(8'($urandom_range(255)));
      finish_frame();
   endtask

   // random frame sizes and contents, stepping through the idling modes at random
   task automatic test_random_frames();
      int start_count, mode;
      start_count = pixels_sent;
      mode = 0;
      while (pixels_sent - start_count < 1550) begin
         set_frame_size($urandom_range(15) == 0 ? $urandom_range(40, 3) : $urandom_range(16, 3),
                        $urandom_range(9, 3));
         set_idle_mode(mode);
         send_frame($urandom_range(3));
         if ($urandom_range(3) == 0) mode = (mode + 1) % 4;
      end
   endtask

   initial begin
      error_count = 0;
      pixels_sent = 0;
      sender_idle_pct = 0;
      sink_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      csr_we = 1'b0;
      csr_addr = REG_WIDTH;
      csr_wdata = 13'd0;
      for (int i = 0; i < MaxWidth; i++) begin
         row_above[i] = 8'd0;
         row_two_up[i] = 8'd0;
      end
      for (int i = 0; i < 6; i++) win[i] = 8'd0;
      col_pos = 0;
      row_pos = 0;
      width_reg = WidthReset;
      height_reg = HeightReset;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_size_extremes();
      test_resize_mid_frame();
      test_random_frames();

      wait_idle();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/sge_pkg.sv
rtl/sge_line_store.sv
rtl/sge_isqrt.sv
rtl/sobel_edge_gradient.sv
tb/sv/tb_top.sv
